// File: src/arpc_pkg.sv
// Shared types and constants for the ARP cache table.
// Holds the action codes, table sizing and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package arpc_pkg;

   // table sizing
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // field widths
   localparam int IP_W  = 32;
   localparam int MAC_W = 48;
   localparam int TTL_W = 16;
   localparam int CNT_W = 6;

   // reset value of the TTL reload register, in ticks
   localparam logic [TTL_W-1:0] TTL_RELOAD_INIT = 16'd15;

   // register map: word index taken from paddr[2]
   localparam int  CSR_AW  = 3;
   localparam logic REG_TTL_RELOAD = 1'b0;

   typedef enum logic [2:0] {
      ACT_LOOKUP  = 3'd0,
      ACT_ADD     = 3'd1,
      ACT_REMOVE  = 3'd2,
      ACT_REFRESH = 3'd3,
      ACT_TICK    = 3'd4,
      ACT_PURGE   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic ld;    // take the request word, restart the scan
      logic scan;  // examine the slot at the scan index
      logic fin;   // commit the pending write and issue the result
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;  // scan index sits on the final slot
   } ctl_sts_type;

endpackage

`default_nettype wire

// File: src/arpc_csr.sv
// APB-style configuration register block for the ARP cache table.
// Holds the TTL reload register; depends on arpc_pkg.
`default_nettype none

module arpc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [arpc_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready,
   output logic      [arpc_pkg::TTL_W-1:0]    ttl_reload
);
   import arpc_pkg::*;

   logic [TTL_W-1:0] ttl_reload_ff;
   logic [TTL_W-1:0] ttl_reload_in;
   logic             reg_sel;
   logic             wr_en;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == REG_TTL_RELOAD);
   assign wr_en   = psel & penable & pwrite & pready & reg_sel;

   // write path
   always_comb begin
      ttl_reload_in = ttl_reload_ff;
      if (wr_en) begin
         ttl_reload_in = pwdata[TTL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_reload_ff <= TTL_RELOAD_INIT;
      end else begin
         ttl_reload_ff <= ttl_reload_in;
      end
   end

   // read path, unmapped words read as zero
   assign prdata     = reg_sel ? {{(32-TTL_W){1'b0}}, ttl_reload_ff} : 32'd0;
   assign ttl_reload = ttl_reload_ff;

endmodule

`default_nettype wire

// File: src/arpc_ctrl.sv
// Sequencing controller for the ARP cache table.
// Steps each request through load, slot scan and finish; depends on arpc_pkg.
`default_nettype none

module arpc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire arpc_pkg::ctl_sts_type sts,
   output arpc_pkg::ctl_cmd_type      cmd
);
   import arpc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.ld   = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.fin  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/arpc_dpath.sv
// Datapath of the ARP cache table: slot storage, scan index, match trackers
// and the result register. Driven by arpc_ctrl; depends on arpc_pkg.
`default_nettype none

module arpc_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire arpc_pkg::ctl_cmd_type         cmd,
   output arpc_pkg::ctl_sts_type              sts,
   input  wire logic [arpc_pkg::TTL_W-1:0]    ttl_reload,
   input  wire logic [2:0]                    req_action,
   input  wire logic [arpc_pkg::IP_W-1:0]     req_ip_addr,
   input  wire logic [arpc_pkg::MAC_W-1:0]    req_mac_addr,
   input  wire logic                          req_is_dynamic,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic      [arpc_pkg::MAC_W-1:0]    rsp_mac_out,
   output logic      [arpc_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic                               rsp_table_full
);
   import arpc_pkg::*;

   // slot storage; only valid bits are reset
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] static_ff;
   logic [IP_W-1:0]        ip_ff  [TABLE_DEPTH];
   logic [MAC_W-1:0]       mac_ff [TABLE_DEPTH];
   logic [TTL_W-1:0]       ttl_ff [TABLE_DEPTH];

   // latched request word
   action_type       act_ff;
   logic [IP_W-1:0]  ip_q_ff;
   logic [MAC_W-1:0] mac_q_ff;
   logic             want_static_ff;

   // scan index and trackers: A is the primary match, B the fallback
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             hit_a_ff, hit_a_in;
   logic [IDX_W-1:0] idx_a_ff, idx_a_in;
   logic             hit_b_ff, hit_b_in;
   logic [IDX_W-1:0] idx_b_ff, idx_b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [MAC_W-1:0] mac_out_ff, mac_out_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full_ff, full_in;

   // single slot port shared by scan and finish
   logic [IDX_W-1:0] fin_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             s_valid, s_static, s_ipm, s_macm, s_kind;
   logic [TTL_W-1:0] s_ttl;
   logic [MAC_W-1:0] s_mac;
   logic             match_a, match_b, bump;

   // slot write controls
   logic             valid_we, valid_wd;
   logic             ttl_we;
   logic [TTL_W-1:0] ttl_wd;
   logic             fill_we;   // static bit and MAC of a new slot
   logic             ip_we;

   assign fin_idx  = hit_a_ff ? idx_a_ff : idx_b_ff;
   assign rd_idx   = cmd.fin ? fin_idx : idx_ff;
   assign s_valid  = valid_ff[rd_idx];
   assign s_static = static_ff[rd_idx];
   assign s_ttl    = ttl_ff[rd_idx];
   assign s_mac    = mac_ff[rd_idx];
   assign s_ipm    = (ip_ff[rd_idx] == ip_q_ff);
   assign s_macm   = (s_mac == mac_q_ff);
   assign s_kind   = (s_static == want_static_ff);

   assign sts.last = (idx_ff == IDX_W'(TABLE_DEPTH - 1));

   // per-slot match and in-place update during the scan
   always_comb begin
      match_a  = 1'b0;
      match_b  = 1'b0;
      bump     = 1'b0;
      valid_we = 1'b0;
      valid_wd = 1'b0;
      ttl_we   = 1'b0;
      ttl_wd   = s_ttl;
      fill_we  = 1'b0;
      ip_we    = 1'b0;
      found_in   = 1'b0;
      mac_out_in = '0;
      count_in   = '0;
      full_in    = 1'b0;
      if (cmd.scan) begin
         unique case (act_ff)
            ACT_LOOKUP: begin
               match_a = s_valid & ~s_static & s_ipm;
               match_b = s_valid & s_static & s_ipm;
            end
            ACT_ADD: begin
               match_a = s_valid & s_kind & s_macm;
               match_b = ~s_valid;
            end
            ACT_REMOVE: begin
               match_a = s_valid & s_kind & s_ipm;
            end
            ACT_REFRESH: begin
               match_a = s_valid & ~s_static & s_macm;
            end
            ACT_TICK: begin
               if (s_valid & ~s_static) begin
                  ttl_we = 1'b1;
                  if (s_ttl <= TTL_W'(1)) begin
                     ttl_wd   = '0;
                     valid_we = 1'b1;
                     bump     = 1'b1;
                  end else begin
                     ttl_wd = s_ttl - TTL_W'(1);
                  end
               end
            end
            ACT_PURGE: begin
               if (s_valid & s_kind) begin
                  valid_we = 1'b1;
                  bump     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // commit at the selected slot and form the result
      if (cmd.fin) begin
         count_in = cnt_ff;
         unique case (act_ff)
            ACT_LOOKUP: begin
               found_in = hit_a_ff | hit_b_ff;
               if (hit_a_ff | hit_b_ff) begin
                  mac_out_in = s_mac;
               end
            end
            ACT_ADD: begin
               if (hit_a_ff) begin
                  ip_we  = 1'b1;
                  ttl_we = 1'b1;
                  ttl_wd = ttl_reload;
               end else if (hit_b_ff) begin
                  valid_we = 1'b1;
                  valid_wd = 1'b1;
                  fill_we  = 1'b1;
                  ip_we    = 1'b1;
                  ttl_we   = 1'b1;
                  ttl_wd   = ttl_reload;
               end else begin
                  full_in = 1'b1;
               end
            end
            ACT_REMOVE: begin
               found_in = hit_a_ff;
               valid_we = hit_a_ff;
            end
            ACT_REFRESH: begin
               found_in = hit_a_ff;
               ttl_we   = hit_a_ff;
               ttl_wd   = ttl_reload;
            end
            default: begin
            end
         endcase
      end
   end

   // scan index and first-match trackers
   always_comb begin
      idx_in   = idx_ff;
      hit_a_in = hit_a_ff;
      idx_a_in = idx_a_ff;
      hit_b_in = hit_b_ff;
      idx_b_in = idx_b_ff;
      cnt_in   = cnt_ff;
      if (cmd.ld) begin
         idx_in   = '0;
         hit_a_in = 1'b0;
         hit_b_in = 1'b0;
         cnt_in   = '0;
      end else if (cmd.scan) begin
         idx_in = idx_ff + IDX_W'(1);
         if (match_a & ~hit_a_ff) begin
            hit_a_in = 1'b1;
            idx_a_in = idx_ff;
         end
         if (match_b & ~hit_b_ff) begin
            hit_b_in = 1'b1;
            idx_b_in = idx_ff;
         end
         // count saturates at the top of its range
         if (bump & (cnt_ff != '1)) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_valid_in = cmd.fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (valid_we) begin
            valid_ff[rd_idx] <= valid_wd;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot payload, no reset
   always_ff @(posedge clock) begin
      if (ttl_we) begin
         ttl_ff[rd_idx] <= ttl_wd;
      end
      if (ip_we) begin
         ip_ff[rd_idx] <= ip_q_ff;
      end
      if (fill_we) begin
         static_ff[rd_idx] <= want_static_ff;
         mac_ff[rd_idx]    <= mac_q_ff;
      end
   end

   // request word, trackers and result word
   always_ff @(posedge clock) begin
      if (cmd.ld) begin
         act_ff         <= action_type'(req_action);
         ip_q_ff        <= req_ip_addr;
         mac_q_ff       <= req_mac_addr;
         want_static_ff <= ~req_is_dynamic;
      end
      idx_ff   <= idx_in;
      hit_a_ff <= hit_a_in;
      idx_a_ff <= idx_a_in;
      hit_b_ff <= hit_b_in;
      idx_b_ff <= idx_b_in;
      cnt_ff   <= cnt_in;
      if (cmd.fin) begin
         found_ff   <= found_in;
         mac_out_ff <= mac_out_in;
         count_ff   <= count_in;
         full_ff    <= full_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_mac_out     = mac_out_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_table_full  = full_ff;

endmodule

`default_nettype wire

// File: src/arp_cache_table.sv
// ARP cache table, top level.
// Uses arpc_pkg, arpc_csr, arpc_ctrl and arpc_dpath.
//
// Usage:
//   Request word: req_action, req_ip_addr, req_mac_addr, req_is_dynamic. It is
//   taken at a rising edge with start high and busy low; busy then stays high
//   until the request is finished.
//   Result word: rsp_found, rsp_mac_out, rsp_entry_count, rsp_table_full,
//   shown for exactly one cycle while rsp_valid is high. The receiver cannot
//   hold it off; the result register is written once per request.
//   Sequence: every request scans all 32 slots one per cycle through a single
//   slot port, then commits to and reads the selected slot in the finish
//   state. rsp_valid rises as that state ends and busy drops in that same
//   cycle; a new request is taken only after the last one has finished.
//   Configuration: APB-style port, ttl_reload at byte address 0, setup phase
//   then access phase, pready always high. Write only while idle.
//   Reset (synchronous, active high): all slots invalid, ttl_reload back to
//   15, controller idle, no result pending.
`default_nettype none

module arp_cache_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_action,
   input  wire logic [arpc_pkg::IP_W-1:0]     req_ip_addr,
   input  wire logic [arpc_pkg::MAC_W-1:0]    req_mac_addr,
   input  wire logic                          req_is_dynamic,
   // result channel
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic      [arpc_pkg::MAC_W-1:0]    rsp_mac_out,
   output logic      [arpc_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic                               rsp_table_full,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [arpc_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);
   import arpc_pkg::*;

   ctl_cmd_type      cmd;
   ctl_sts_type      sts;
   logic [TTL_W-1:0] ttl_reload;

   arpc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .ttl_reload (ttl_reload)
   );

   arpc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   arpc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .ttl_reload      (ttl_reload),
      .req_action      (req_action),
      .req_ip_addr     (req_ip_addr),
      .req_mac_addr    (req_mac_addr),
      .req_is_dynamic  (req_is_dynamic),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_mac_out     (rsp_mac_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_table_full  (rsp_table_full)
   );

endmodule

`default_nettype wire
